// File: sv/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// condition in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// File: sv/dq_pkg.sv
package dq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 64;

  typedef logic signed [DATA_W-1:0] data_t;

  // request opcodes
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_DISPLAY   = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DELETED  = 3'd1;
  localparam logic [2:0] ST_SHOWN    = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_POP_BACK,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    data_t    value;
  } cell_cmd_t;

endpackage

// File: sv/double_ended_queue_unit.sv
// Bounded double-ended queue of signed 32-bit items, kept in a row of DEPTH
// identical cells. Every cell holds one position of each of two rows: one
// row runs front to back and one back to front, so both ends of the queue
// always sit in the first cell and every operation shifts at most one whole row.
// Insert front, insert back, delete front and delete back each produce one
// result item; a new request is accepted in the cycle after the previous one
// whenever the output register is empty or being drained. Display of n
// stored items gives n result items, one per cycle, paced by the output
// register; the front-to-back row rotates once per item and is back in its
// original order after the last one. Display or delete on an empty queue
// gives one queue-empty item, insert on a full queue gives one queue-full
// item and changes nothing, opcodes 5 to 7 are accepted and give no result.
// The cell storage has no reset and no clearing pass; only the item count
// and control state are cleared.
`include "assert_macros.svh"

module double_ended_queue_unit #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_opcode,
  input  logic signed [31:0]  in_item_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic signed [31:0]  out_result_value,
  output logic                out_last_result
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // one-hot control state
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SHOW = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   show_k_r, show_k_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  dq_pkg::data_t      out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;

  dq_pkg::cell_cmd_t  cmd;
  dq_pkg::data_t      f_head;
  dq_pkg::data_t      r_head;

  logic               out_free;
  logic               in_fire;
  logic               empty;
  logic               full;
  logic               show_last;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  // display walks positions 0 .. count-1
  assign show_last = (CNT_W'(show_k_r) == CNT_W'(count_r - CNT_W'(1)));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    show_k_nxt     = show_k_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    cmd.op         = dq_pkg::CELL_HOLD;
    cmd.value      = in_item_value;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_opcode)
            dq_pkg::OP_INS_FRONT,
            dq_pkg::OP_INS_BACK: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_status_nxt = dq_pkg::ST_FULL;
              end else begin
                out_status_nxt = dq_pkg::ST_INSERTED;
                count_nxt      = count_r + CNT_W'(1);
                cmd.op         = (in_opcode == dq_pkg::OP_INS_FRONT) ?
                                 dq_pkg::CELL_PUSH_FRONT : dq_pkg::CELL_PUSH_BACK;
              end
            end
            dq_pkg::OP_DISPLAY: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dq_pkg::ST_EMPTY;
                out_value_nxt  = '0;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt  = S_SHOW;
                show_k_nxt = '0;
              end
            end
            dq_pkg::OP_DEL_FRONT,
            dq_pkg::OP_DEL_BACK: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (empty) begin
                out_status_nxt = dq_pkg::ST_EMPTY;
                out_value_nxt  = '0;
              end else begin
                out_status_nxt = dq_pkg::ST_DELETED;
                count_nxt      = count_r - CNT_W'(1);
                if (in_opcode == dq_pkg::OP_DEL_FRONT) begin
                  out_value_nxt = f_head;
                  cmd.op        = dq_pkg::CELL_POP_FRONT;
                end else begin
                  out_value_nxt = r_head;
                  cmd.op        = dq_pkg::CELL_POP_BACK;
                end
              end
            end
            default: ;  // undefined opcode: no result, no change
          endcase
        end
      end
      S_SHOW: begin
        // emit the front cell, then rotate it to the back of the row
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dq_pkg::ST_SHOWN;
          out_value_nxt  = f_head;
          out_last_nxt   = show_last;
          cmd.op         = dq_pkg::CELL_ROTATE;
          show_k_nxt     = show_k_r + IDX_W'(1);
          if (show_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      show_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      show_k_r    <= show_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  dq_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk    (clk),
    .cmd    (cmd),
    .count  (count_r),
    .f_head (f_head),
    .r_head (r_head)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_last_result  = out_last_r;

  // display only runs over a non-empty queue, index inside the stored range
  `ASSERT_SAME(a_show_in_range, clk, rst_n, state_r == S_SHOW,
               count_r != '0 && CNT_W'(show_k_r) < count_r)
  // an accepted insert into a non-full queue grows the count by one
  `ASSERT_NEXT(a_insert_count, clk, rst_n,
               in_fire && !full && (in_opcode == dq_pkg::OP_INS_FRONT ||
                                    in_opcode == dq_pkg::OP_INS_BACK),
               count_r == $past(count_r) + CNT_W'(1))
  // display leaves the count alone
  `ASSERT_NEXT(a_show_count, clk, rst_n, state_r == S_SHOW,
               count_r == $past(count_r))
  // the last displayed item ends the display
  `ASSERT_NEXT(a_show_ends, clk, rst_n, state_r == S_SHOW && out_free && show_last,
               state_r == S_IDLE && out_valid_r && out_last_r)

endmodule

// File: sv/dq_cell.sv
module dq_cell #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
  parameter int IDX = 0,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  dq_pkg::cell_cmd_t cmd,
  input  logic [CNT_W-1:0]  count,
  input  dq_pkg::data_t     f_left,
  input  dq_pkg::data_t     f_right,
  input  dq_pkg::data_t     r_left,
  input  dq_pkg::data_t     r_right,
  input  dq_pkg::data_t     f_head,
  output dq_pkg::data_t     f_q,
  output dq_pkg::data_t     r_q
);

  // f holds the queue front to back, r holds it back to front
  dq_pkg::data_t f_r, f_nxt;
  dq_pkg::data_t r_r, r_nxt;
  logic          hit;
  logic          last;

  assign hit  = (count == CNT_W'(IDX));
  assign last = (count == CNT_W'(IDX + 1));

  always_comb begin
    f_nxt = f_r;
    r_nxt = r_r;
    case (cmd.op)
      dq_pkg::CELL_PUSH_FRONT: begin
        f_nxt = f_left;
        if (hit) r_nxt = cmd.value;
      end
      dq_pkg::CELL_PUSH_BACK: begin
        if (hit) f_nxt = cmd.value;
        r_nxt = r_left;
      end
      dq_pkg::CELL_POP_FRONT: f_nxt = f_right;
      dq_pkg::CELL_POP_BACK:  r_nxt = r_right;
      dq_pkg::CELL_ROTATE:    f_nxt = last ? f_head : f_right;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
    r_r <= r_nxt;
  end

  assign f_q = f_r;
  assign r_q = r_r;

endmodule

// File: sv/dq_chain.sv
module dq_chain #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  dq_pkg::cell_cmd_t cmd,
  input  logic [CNT_W-1:0]  count,
  output dq_pkg::data_t     f_head,
  output dq_pkg::data_t     r_head
);

  dq_pkg::data_t f_q [DEPTH];
  dq_pkg::data_t r_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_pkg::data_t f_left, f_right, r_left, r_right;

    // the head cell shifts in the new item, the tail cell shifts in zero
    if (i == 0) begin : g_head
      assign f_left = cmd.value;
      assign r_left = cmd.value;
    end else begin : g_mid
      assign f_left = f_q[i-1];
      assign r_left = r_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign f_right = '0;
      assign r_right = '0;
    end else begin : g_body
      assign f_right = f_q[i+1];
      assign r_right = r_q[i+1];
    end

    dq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .count   (count),
      .f_left  (f_left),
      .f_right (f_right),
      .r_left  (r_left),
      .r_right (r_right),
      .f_head  (f_q[0]),
      .f_q     (f_q[i]),
      .r_q     (r_q[i])
    );
  end

  assign f_head = f_q[0];
  assign r_head = r_q[0];

endmodule
